@@ hdl/prescaled_timer_bank_unit_assert.svh @@
// assertion macros for the prescaled timer bank
`ifndef PRESCALED_TIMER_BANK_UNIT_ASSERT_SVH
`define PRESCALED_TIMER_BANK_UNIT_ASSERT_SVH

// same-cycle implication
`define PTB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ptb_pkg.sv @@
// shared types and constants of the prescaled timer bank
package ptb_pkg;

    localparam int TIMER_COUNT = 16;
    localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int ID_W        = 8;
    localparam int VAL_W       = 32;
    localparam int PRE_W       = 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_START   = 3'd1,
        OP_STOP    = 3'd2,
        OP_LOAD    = 3'd3,
        OP_SERVICE = 3'd4,
        OP_QUERY   = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_SWEEP_END,
        S_RD,
        S_UPD,
        S_SVC_RD,
        S_SVC_CHK,
        S_SVC_END
    } t_state;

    typedef struct packed {
        logic             active;
        logic             periodic;
        logic [VAL_W-1:0] reload;
        logic [VAL_W-1:0] remaining;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic             kind;
        logic [ID_W-1:0]  timer;
        logic             bad;
        logic             active;
        logic [VAL_W-1:0] remaining;
        logic             periodic;
        logic [VAL_W-1:0] reload;
    } t_res;

endpackage

@@ hdl/ptb_if.sv @@
// item channels of the prescaled timer bank
interface ptb_in_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                operation;
    logic [ptb_pkg::ID_W-1:0]  timer_sel;
    logic [ptb_pkg::VAL_W-1:0] count_value;
    logic                      periodic_mode;

    modport source (output valid, operation, timer_sel, count_value, periodic_mode,
                    input ready);
    modport sink   (input valid, operation, timer_sel, count_value, periodic_mode,
                    output ready);
endinterface

interface ptb_out_if;
    logic                      valid;
    logic                      ready;
    logic                      result_kind;
    logic [ptb_pkg::ID_W-1:0]  result_timer;
    logic                      bad_id;
    logic                      is_active;
    logic [ptb_pkg::VAL_W-1:0] remaining;
    logic                      is_periodic;
    logic [ptb_pkg::VAL_W-1:0] reload_period;
    logic                      last_result;

    modport source (output valid, result_kind, result_timer, bad_id, is_active, remaining,
                           is_periodic, reload_period, last_result,
                    input ready);
    modport sink   (input valid, result_kind, result_timer, bad_id, is_active, remaining,
                          is_periodic, reload_period, last_result,
                    output ready);
endinterface

@@ hdl/ptb_ram.sv @@
// generic single-write, single-read memory with registered read
module ptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/ptb_cfg.sv @@
// configuration register file (tick divisor) behind the apb port
module ptb_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ptb_pkg::PADDR_W-1:0] paddr,
    input  logic [ptb_pkg::PDATA_W-1:0] pwdata,
    output logic [ptb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [ptb_pkg::PRE_W-1:0]   o_divisor
);
    import ptb_pkg::*;

    logic [PRE_W-1:0] r_divisor;
    logic             sel_div;

    assign sel_div = (paddr[PADDR_W-1:2] == '0);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= PRE_W'(1);
        end else if (psel && penable && pwrite && pready && sel_div) begin
            r_divisor <= pwdata[PRE_W-1:0];
        end
    end

    assign prdata    = sel_div ? PDATA_W'(r_divisor) : '0;
    assign o_divisor = r_divisor;

endmodule

@@ hdl/prescaled_timer_bank_unit.sv @@
// top level of the prescaled timer bank: sequencer, prescaler and result register
//
// channel   dir  handshake       payload
// i_cmd     in   valid/ready     operation, timer_sel, count_value, periodic_mode
// o_res     out  valid/ready     result fields and last_result
// apb       in   psel/penable    tick_divisor at byte address 0
//
// start, stop, load count, query and a tick without rollover: read the entry, then update it and push the result
// tick with prescaler rollover: a sweep of every entry first, one entry a cycle through the ram
// service: read then check per entry, plus output stalls
// reset clears control state and the per-entry valid bits, no clearing pass
// a full result register stalls the sequencer; a new item is taken while a result waits
`include "prescaled_timer_bank_unit_assert.svh"

module prescaled_timer_bank_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ptb_in_if.sink                      i_cmd,
    ptb_out_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ptb_pkg::PADDR_W-1:0] paddr,
    input  logic [ptb_pkg::PDATA_W-1:0] pwdata,
    output logic [ptb_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import ptb_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

    function automatic t_res mk_res(input logic kind, input logic [ID_W-1:0] id,
                                    input logic ok, input t_entry e);
        t_res r;
        r.kind  = kind;
        r.timer = id;
        if (ok) begin
            r.bad       = 1'b0;
            r.active    = e.active;
            r.remaining = e.remaining;
            r.periodic  = e.periodic;
            r.reload    = e.reload;
        end else begin
            r.bad       = 1'b1;
            r.active    = 1'b0;
            r.remaining = '0;
            r.periodic  = 1'b1;
            r.reload    = '0;
        end
        return r;
    endfunction

    logic [PRE_W-1:0] divisor;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [ID_W-1:0]  r_id, n_id;
    logic             r_ok, n_ok;
    logic [VAL_W-1:0] r_val, n_val;
    logic             r_per, n_per;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_wb_addr, n_wb_addr;
    logic [PRE_W-1:0] r_pre, n_pre;
    logic [TIMER_COUNT-1:0] r_valid;
    logic             r_rd_vld;
    logic             r_hold_valid, n_hold_valid;
    t_res             r_hold, n_hold;
    t_res             r_out;
    logic             r_out_last;
    logic             r_out_valid;

    logic             in_acc;
    logic             out_free;
    logic [PRE_W-1:0] pre_inc;
    logic             pre_fire;
    logic             ok_in;
    t_op              op_in;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] ram_q;
    t_entry             rd_entry;
    t_entry             dec_entry;
    t_entry             upd_entry;
    t_entry             svc_entry;
    logic               expired;
    logic               svc_go;
    logic               push;
    t_res               push_res;
    logic               push_last;

    ptb_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_divisor(divisor)
    );

    ptb_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TIMER_COUNT)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(ram_q)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign in_acc      = i_cmd.valid && i_cmd.ready;
    assign op_in       = t_op'(i_cmd.operation);
    assign ok_in       = (i_cmd.timer_sel < ID_W'(TIMER_COUNT));
    assign out_free    = !r_out_valid || o_res.ready;
    assign pre_inc     = r_pre + 1'b1;
    assign pre_fire    = (pre_inc >= divisor) || (pre_inc == '0);

    // never-written entries read as zero
    assign rd_entry = r_rd_vld ? t_entry'(ram_q) : '0;

    always_comb begin
        dec_entry = rd_entry;
        if (rd_entry.active && (rd_entry.remaining != '0)) begin
            dec_entry.remaining = rd_entry.remaining - 1'b1;
        end
    end

    always_comb begin
        upd_entry = rd_entry;
        case (r_op)
            OP_START: begin
                upd_entry.active    = 1'b1;
                upd_entry.periodic  = r_per;
                upd_entry.reload    = r_val;
                upd_entry.remaining = r_val;
            end
            OP_STOP: begin
                upd_entry = '0;
            end
            OP_LOAD: begin
                upd_entry.remaining = VAL_W'(r_val[15:0]);
            end
            default: begin
                upd_entry = rd_entry;
            end
        endcase
    end

    always_comb begin
        svc_entry = rd_entry;
        if (rd_entry.periodic) begin
            svc_entry.remaining = rd_entry.reload;
        end else begin
            svc_entry.active = 1'b0;
        end
    end

    assign expired = rd_entry.active && (rd_entry.remaining == '0);
    assign svc_go  = !expired || !r_hold_valid || out_free;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (op_in)
                        OP_TICK:    n_state = pre_fire ? S_SWEEP : S_RD;
                        OP_SERVICE: n_state = S_SVC_RD;
                        default:    n_state = S_RD;
                    endcase
                end
            end
            S_SWEEP: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_SWEEP_END;
                end
            end
            S_SWEEP_END: n_state = S_RD;
            S_RD:        n_state = S_UPD;
            S_UPD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SVC_RD:    n_state = S_SVC_CHK;
            S_SVC_CHK: begin
                if (svc_go) begin
                    n_state = (r_idx == LAST_IDX) ? S_SVC_END : S_SVC_RD;
                end
            end
            S_SVC_END: begin
                if (!r_hold_valid || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op         = r_op;
        n_id         = r_id;
        n_ok         = r_ok;
        n_val        = r_val;
        n_per        = r_per;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_wb_addr    = r_wb_addr;
        n_pre        = r_pre;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = rd_entry;
        rd_en        = 1'b0;
        rd_addr      = r_idx;
        push         = 1'b0;
        push_res     = r_hold;
        push_last    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op         = op_in;
                    n_id         = i_cmd.timer_sel;
                    n_ok         = ok_in;
                    n_val        = i_cmd.count_value;
                    n_per        = i_cmd.periodic_mode;
                    n_idx        = '0;
                    n_pend       = 1'b0;
                    n_hold_valid = 1'b0;
                    if (op_in == OP_TICK) begin
                        n_pre = pre_fire ? '0 : pre_inc;
                    end
                end
            end
            S_SWEEP: begin
                rd_en     = 1'b1;
                rd_addr   = r_idx;
                n_pend    = 1'b1;
                n_wb_addr = r_idx;
                wr_en     = r_pend;
                wr_addr   = r_wb_addr;
                wr_data   = dec_entry;
                if (r_idx != LAST_IDX) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SWEEP_END: begin
                wr_en   = r_pend;
                wr_addr = r_wb_addr;
                wr_data = dec_entry;
                n_pend  = 1'b0;
            end
            S_RD: begin
                rd_en   = r_ok;
                rd_addr = r_id[IDX_W-1:0];
            end
            S_UPD: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_res  = mk_res(1'b0, r_id, r_ok, upd_entry);
                    push_last = 1'b1;
                    wr_en     = r_ok && ((r_op == OP_START) || (r_op == OP_STOP) ||
                                         (r_op == OP_LOAD));
                    wr_addr   = r_id[IDX_W-1:0];
                    wr_data   = upd_entry;
                end
            end
            S_SVC_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_idx;
            end
            S_SVC_CHK: begin
                if (svc_go) begin
                    if (expired) begin
                        wr_en        = 1'b1;
                        wr_addr      = r_idx;
                        wr_data      = svc_entry;
                        push         = r_hold_valid;
                        push_res     = r_hold;
                        n_hold       = mk_res(1'b1, ID_W'(r_idx), 1'b1, svc_entry);
                        n_hold_valid = 1'b1;
                    end
                    if (r_idx != LAST_IDX) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_SVC_END: begin
                if (r_hold_valid && out_free) begin
                    push         = 1'b1;
                    push_res     = r_hold;
                    push_last    = 1'b1;
                    n_hold_valid = 1'b0;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend       <= 1'b0;
            r_pre        <= '0;
            r_valid      <= '0;
            r_rd_vld     <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend       <= n_pend;
            r_pre        <= n_pre;
            r_hold_valid <= n_hold_valid;
            if (rd_en) begin
                r_rd_vld <= r_valid[rd_addr];
            end
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_id      <= n_id;
        r_ok      <= n_ok;
        r_val     <= n_val;
        r_per     <= n_per;
        r_idx     <= n_idx;
        r_wb_addr <= n_wb_addr;
        r_hold    <= n_hold;
        if (push) begin
            r_out      <= push_res;
            r_out_last <= push_last;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.result_kind   = r_out.kind;
    assign o_res.result_timer  = r_out.timer;
    assign o_res.bad_id        = r_out.bad;
    assign o_res.is_active     = r_out.active;
    assign o_res.remaining     = r_out.remaining;
    assign o_res.is_periodic   = r_out.periodic;
    assign o_res.reload_period = r_out.reload;
    assign o_res.last_result   = r_out_last;

    `PTB_ASSERT_NOW(a_no_wr_idle, i_clk, i_rst_n, r_state == S_IDLE, !wr_en, "ram write while idle")
    `PTB_ASSERT_NOW(a_sweep_order, i_clk, i_rst_n, (r_state == S_SWEEP) && r_pend, r_wb_addr == IDX_W'(r_idx - 1'b1), "sweep write-back not one entry behind read")
    `PTB_ASSERT_NOW(a_hold_scope, i_clk, i_rst_n, r_hold_valid, (r_state == S_SVC_RD) || (r_state == S_SVC_CHK) || (r_state == S_SVC_END), "held expiry outside a service scan")
    `PTB_ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n, in_acc, r_state != S_IDLE, "sequencer idle right after taking an item")

endmodule
